@@ rtl/core/rgbc_to_hsl_convert_top_assert.svh @@
// Assertion macros for the RGBC to HSL converter.
// Used by rgbc_to_hsl_convert_top; expects clk and rst_n in scope.
`ifndef RGBC_TO_HSL_CONVERT_TOP_ASSERT_SVH
`define RGBC_TO_HSL_CONVERT_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RGBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RGBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rgbc_pkg.sv @@
// Shared types and constants for the RGBC to HSL converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } hue_sel_t;

  localparam int QBITS = 7;  // quotient bits of hue and saturation dividers

  localparam logic [8:0] HUE_FULL  = 9'd360;
  localparam logic [8:0] HUE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BLUE  = 9'd240;
  localparam logic [8:0] SAT_SPAN  = 9'd510;

  // one word in the hue / saturation half of the pipe
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       cz;
    hue_sel_t   sel;
    logic       neg;
    logic       dz;
    logic [7:0] light;
    logic [7:0] dif;
    logic [7:0] hrem;
    logic [6:0] hlow;
    logic [6:0] hq;
    logic [8:0] sden;
    logic [8:0] srem;
    logic [6:0] slow;
    logic [6:0] sq;
  } hsl_stage_t;

endpackage

`default_nettype wire

@@ rtl/core/rgbc_div_step.sv @@
// One restoring-division step: shift in a numerator bit, trial subtract.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_div_step #(
  parameter int W = 16
) (
  input  wire logic [W-1:0] rem_i,   // < den_i
  input  wire logic         bit_i,
  input  wire logic [W-1:0] den_i,
  output logic      [W-1:0] rem_o,
  output logic              q_o
);

  logic [W:0] trial;
  logic [W:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, den_i};
  assign q_o   = (trial >= {1'b0, den_i});
  assign rem_o = q_o ? diff[W-1:0] : trial[W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/rgbc_hsl_prep.sv @@
// Max/min, lightness, hue sector and divider operands from normalized RGB.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_hsl_prep (
  input  wire logic [7:0]          r_i,
  input  wire logic [7:0]          g_i,
  input  wire logic [7:0]          b_i,
  input  wire logic                cz_i,
  output rgbc_pkg::hsl_stage_t     st_o
);

  logic [7:0]  mx, mn, x, y, mag;
  logic [8:0]  sum;
  logic [13:0] hn;
  logic [14:0] sn;
  rgbc_pkg::hue_sel_t sel;

  always_comb begin
    mx = r_i;
    if (g_i > mx) mx = g_i;
    if (b_i > mx) mx = b_i;
    mn = r_i;
    if (g_i < mn) mn = g_i;
    if (b_i < mn) mn = b_i;
    // ties go to red, then green
    if (mx == r_i) begin
      sel = rgbc_pkg::SEL_RED;
      x = g_i;
      y = b_i;
    end else if (mx == g_i) begin
      sel = rgbc_pkg::SEL_GREEN;
      x = b_i;
      y = r_i;
    end else begin
      sel = rgbc_pkg::SEL_BLUE;
      x = r_i;
      y = g_i;
    end
    mag = (x < y) ? (y - x) : (x - y);
  end

  assign sum = {1'b0, mx} + {1'b0, mn};
  assign hn  = {6'd0, mag} * 14'd60;
  assign sn  = {7'd0, (mx - mn)} * 15'd100;

  always_comb begin
    st_o       = '0;
    st_o.r     = r_i;
    st_o.g     = g_i;
    st_o.b     = b_i;
    st_o.cz    = cz_i;
    st_o.sel   = sel;
    st_o.neg   = (x < y);
    st_o.dif   = mx - mn;
    st_o.dz    = (mx == mn);
    st_o.light = sum[8:1];
    st_o.hrem  = {1'b0, hn[13:7]};
    st_o.hlow  = hn[6:0];
    st_o.sden  = sum[8] ? (rgbc_pkg::SAT_SPAN - sum) : sum;
    st_o.srem  = {1'b0, sn[14:7]};
    st_o.slow  = sn[6:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/rgbc_to_hsl_convert_top.sv @@
// RGBC to HSL converter, top level: normalize pipe, HSL pipe, output register.
// Depends on rgbc_pkg, rgbc_div_step, rgbc_hsl_prep and the assertion header.
//
// Usage:
//  - Input channel in_*: raw red, green, blue and clear counts. A word is
//    taken at a rising edge with in_valid high and in_stall low.
//  - Output channel out_*: normalized RGB (count*255/clear, 255 when the
//    color count reaches clear), hue 0..360 degrees, saturation 0..100
//    percent, lightness 0..255 and clear_zero. A zero clear count gives
//    all-zero fields with clear_zero set.
//  - A word passes the normalize pipe, stage A, the hue and saturation pipe
//    and the output register. Throughput: one word per cycle while the
//    pipe is not held. Bit-serial dividers: 8 steps for the normalizing
//    divide, 7 for hue and saturation, one register stage per quotient bit.
//  - Reset (rst_n low, synchronous) empties the pipe: all valid bits clear.
//  - When out_valid is high and out_stall is high the whole pipe holds and
//    in_stall rises in the same cycle; nothing is lost or repeated.
//  - No configuration; every word is independent.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_to_hsl_convert_top #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COUNT_BITS-1:0] in_red_count,
  input  wire logic [COUNT_BITS-1:0] in_green_count,
  input  wire logic [COUNT_BITS-1:0] in_blue_count,
  input  wire logic [COUNT_BITS-1:0] in_clear_count,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_norm_red,
  output logic [7:0]                 out_norm_green,
  output logic [7:0]                 out_norm_blue,
  output logic [8:0]                 out_hue,
  output logic [6:0]                 out_saturation,
  output logic [7:0]                 out_lightness,
  output logic                       out_clear_zero
);

  localparam int CB = COUNT_BITS;
  localparam int NW = COUNT_BITS + 8;   // count*255
  localparam int NS = 8;                // normalize divide steps
  localparam int HS = rgbc_pkg::QBITS;  // hue / saturation divide steps

  // whole pipe moves unless the finished word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- input stage: count*255 split for the divider
  logic [CB-1:0] cnt_in [0:2];
  logic [NW-1:0] nfull  [0:2];
  assign cnt_in[0] = in_red_count;
  assign cnt_in[1] = in_green_count;
  assign cnt_in[2] = in_blue_count;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nfull[c] = {cnt_in[c], 8'd0} - {8'd0, cnt_in[c]};
    end
  end

  // ---------------- normalize pipe, one quotient bit per stage
  logic          nv_r   [0:NS];
  logic          ncz_r  [0:NS];
  logic [2:0]    nsat_r [0:NS];
  logic [7:0]    nq_r   [0:NS][0:2];
  logic [CB-1:0] nrem_r [0:NS-1][0:2];
  logic [7:0]    nlow_r [0:NS-1][0:2];
  logic [CB-1:0] ncl_r  [0:NS-1];

  wire  [CB-1:0] nrem_nxt [1:NS][0:2];
  wire           nqb_nxt  [1:NS][0:2];

  genvar gj, gc;
  generate
    for (gj = 1; gj <= NS; gj++) begin : g_nstep
      for (gc = 0; gc < 3; gc++) begin : g_ch
        rgbc_div_step #(.W(CB)) u_step (
          .rem_i (nrem_r[gj-1][gc]),
          .bit_i (nlow_r[gj-1][gc][NS-gj]),
          .den_i (ncl_r[gj-1]),
          .rem_o (nrem_nxt[gj][gc]),
          .q_o   (nqb_nxt[gj][gc])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) nv_r[j] <= 1'b0;
    end else if (adv) begin
      nv_r[0]   <= in_valid;
      ncz_r[0]  <= (in_clear_count == '0);
      ncl_r[0]  <= in_clear_count;
      for (int c = 0; c < 3; c++) begin
        nsat_r[0][c]  <= (cnt_in[c] >= in_clear_count);
        nq_r[0][c]    <= 8'd0;
        nrem_r[0][c]  <= nfull[c][NW-1:8];
        nlow_r[0][c]  <= nfull[c][7:0];
      end
      for (int j = 1; j <= NS; j++) begin
        nv_r[j]   <= nv_r[j-1];
        ncz_r[j]  <= ncz_r[j-1];
        nsat_r[j] <= nsat_r[j-1];
        for (int c = 0; c < 3; c++) begin
          nq_r[j][c] <= {nq_r[j-1][c][6:0], nqb_nxt[j][c]};
        end
      end
      for (int j = 1; j < NS; j++) begin
        ncl_r[j] <= ncl_r[j-1];
        for (int c = 0; c < 3; c++) begin
          nrem_r[j][c] <= nrem_nxt[j][c];
          nlow_r[j][c] <= nlow_r[j-1][c];
        end
      end
    end
  end

  // ---------------- stage A: saturate / zero-clear fixup
  logic       va_r, cza_r;
  logic [7:0] ch_a_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r  <= nv_r[NS];
      cza_r <= ncz_r[NS];
      for (int c = 0; c < 3; c++) begin
        if (ncz_r[NS])        ch_a_r[c] <= 8'd0;
        else if (nsat_r[NS][c]) ch_a_r[c] <= 8'd255;
        else                  ch_a_r[c] <= nq_r[NS][c];
      end
    end
  end

  // ---------------- stage B: max/min, sector, divider operands
  rgbc_pkg::hsl_stage_t prep_nxt;

  rgbc_hsl_prep u_prep (
    .r_i  (ch_a_r[0]),
    .g_i  (ch_a_r[1]),
    .b_i  (ch_a_r[2]),
    .cz_i (cza_r),
    .st_o (prep_nxt)
  );

  // ---------------- hue and saturation divide pipe
  logic                 hv_r [0:HS];
  rgbc_pkg::hsl_stage_t hd_r [0:HS];

  wire [7:0] hrem_nxt [1:HS];
  wire       hqb_nxt  [1:HS];
  wire [8:0] srem_nxt [1:HS];
  wire       sqb_nxt  [1:HS];

  genvar gk;
  generate
    for (gk = 1; gk <= HS; gk++) begin : g_hstep
      rgbc_div_step #(.W(8)) u_hue (
        .rem_i (hd_r[gk-1].hrem),
        .bit_i (hd_r[gk-1].hlow[HS-gk]),
        .den_i (hd_r[gk-1].dif),
        .rem_o (hrem_nxt[gk]),
        .q_o   (hqb_nxt[gk])
      );
      rgbc_div_step #(.W(9)) u_sat (
        .rem_i (hd_r[gk-1].srem),
        .bit_i (hd_r[gk-1].slow[HS-gk]),
        .den_i (hd_r[gk-1].sden),
        .rem_o (srem_nxt[gk]),
        .q_o   (sqb_nxt[gk])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    rgbc_pkg::hsl_stage_t st;
    if (!rst_n) begin
      for (int k = 0; k <= HS; k++) hv_r[k] <= 1'b0;
    end else if (adv) begin
      hv_r[0] <= va_r;
      hd_r[0] <= prep_nxt;
      for (int k = 1; k <= HS; k++) begin
        st      = hd_r[k-1];
        st.hrem = hrem_nxt[k];
        st.hq   = {hd_r[k-1].hq[5:0], hqb_nxt[k]};
        st.srem = srem_nxt[k];
        st.sq   = {hd_r[k-1].sq[5:0], sqb_nxt[k]};
        hv_r[k] <= hv_r[k-1];
        hd_r[k] <= st;
      end
    end
  end

  // ---------------- hue assembly and output register
  rgbc_pkg::hsl_stage_t fin;
  logic [8:0] q9, hue_nxt;
  logic [6:0] sat_nxt;

  assign fin = hd_r[HS];
  assign q9  = {2'd0, fin.hq};

  always_comb begin
    case (fin.sel)
      rgbc_pkg::SEL_RED:   hue_nxt = fin.neg ? (rgbc_pkg::HUE_FULL - q9) : q9;
      rgbc_pkg::SEL_GREEN: hue_nxt = fin.neg ? (rgbc_pkg::HUE_GREEN - q9)
                                             : (rgbc_pkg::HUE_GREEN + q9);
      rgbc_pkg::SEL_BLUE:  hue_nxt = fin.neg ? (rgbc_pkg::HUE_BLUE - q9)
                                             : (rgbc_pkg::HUE_BLUE + q9);
      default:             hue_nxt = 9'd0;
    endcase
    if (fin.dz) hue_nxt = 9'd0;
    sat_nxt = fin.dz ? 7'd0 : fin.sq;
  end

  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r    <= hv_r[HS];
      out_norm_red   <= fin.r;
      out_norm_green <= fin.g;
      out_norm_blue  <= fin.b;
      out_hue        <= hue_nxt;
      out_saturation <= sat_nxt;
      out_lightness  <= fin.light;
      out_clear_zero <= fin.cz;
    end
  end

  // ---------------- assertions
`include "rgbc_to_hsl_convert_top_assert.svh"

  `RGBC_ASSERT_NOW(a_cz_zero, out_valid && out_clear_zero,
    out_norm_red == 8'd0 && out_norm_green == 8'd0 && out_norm_blue == 8'd0 &&
    out_hue == 9'd0 && out_saturation == 7'd0 && out_lightness == 8'd0,
    "zero clear word has nonzero fields")
  `RGBC_ASSERT_NOW(a_range, out_valid,
    out_hue <= 9'd360 && out_saturation <= 7'd100, "hue or saturation out of range")
  `RGBC_ASSERT_NOW(a_gray, out_valid && out_norm_red == out_norm_green &&
    out_norm_green == out_norm_blue,
    out_hue == 9'd0 && out_saturation == 7'd0, "gray word has hue or saturation")
  `RGBC_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(out_hue) && $stable(out_norm_red) && $stable(out_clear_zero),
    "held word changed")

endmodule

`default_nettype wire
